// ===== design/p2s_pkg.sv =====
// Shared types, constants and the gradient table for the P2 triangle stiffness block.
// Used by p2s_rdiv and p2_triangle_stiffness_entry; depends on nothing else.
`timescale 1ns / 1ps

package p2s_pkg;

   // Default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;
   // Accumulator width: the weighted sum stays below 2^75 in magnitude
   localparam int ACC_W = 76;
   // Width of a basis pair coefficient (magnitude at most 384)
   localparam int COEF_W = 11;
   // Odd factor of the final divisor 54 * 2^FRAC_BITS
   localparam int DIV_K = 27;
   // Cycles from item acceptance to the result strobe
   localparam int LATENCY = 9;
   localparam int NUM_BASIS = 6;
   localparam int NUM_QP = 3;
   // Highest valid basis index; larger codes act as this one
   localparam logic [2:0] BASIS_LAST = 3'd5;

   typedef logic signed [4:0] grad_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type c00;
      coef_type c01;
      coef_type c11;
   } coef_set_type;

   // Control travelling with an item through the divide stages
   typedef struct packed {
      logic valid;
      logic neg;
   } tag_type;

   // Three times the basis gradients (x, y) at the three quadrature points
   localparam grad_type GRAD3 [NUM_BASIS][NUM_QP][2] = '{
      '{'{-5'sd5, -5'sd5}, '{ 5'sd1,  5'sd1}, '{ 5'sd1,  5'sd1}},
      '{'{-5'sd1,  5'sd0}, '{ 5'sd5,  5'sd0}, '{-5'sd1,  5'sd0}},
      '{'{ 5'sd0, -5'sd1}, '{ 5'sd0, -5'sd1}, '{ 5'sd0,  5'sd5}},
      '{'{ 5'sd6, -5'sd2}, '{-5'sd6, -5'sd8}, '{ 5'sd0, -5'sd2}},
      '{'{ 5'sd2,  5'sd2}, '{ 5'sd2,  5'sd8}, '{ 5'sd8,  5'sd2}},
      '{'{-5'sd2,  5'sd6}, '{-5'sd2,  5'sd0}, '{-5'sd8, -5'sd6}}
   };

   // Sum the gradient products of a basis pair over the quadrature points
   function automatic coef_set_type basis_coef(input logic [2:0] row_raw,
                                               input logic [2:0] col_raw);
      logic [2:0] bi;
      logic [2:0] bj;
      coef_set_type c;
      bi = (row_raw > BASIS_LAST) ? BASIS_LAST : row_raw;
      bj = (col_raw > BASIS_LAST) ? BASIS_LAST : col_raw;
      c = '0;
      for (int k = 0; k < NUM_QP; k++) begin
         c.c00 = c.c00 + coef_type'(GRAD3[bi][k][0]) * coef_type'(GRAD3[bj][k][0]);
         c.c01 = c.c01 + coef_type'(GRAD3[bi][k][0]) * coef_type'(GRAD3[bj][k][1])
                       + coef_type'(GRAD3[bi][k][1]) * coef_type'(GRAD3[bj][k][0]);
         c.c11 = c.c11 + coef_type'(GRAD3[bi][k][1]) * coef_type'(GRAD3[bj][k][1]);
      end
      return c;
   endfunction

endpackage

// ===== design/p2_triangle_stiffness_entry.sv =====
// Top level of the P2 triangle stiffness entry: Jacobian products, weighting, rounding.
// Depends on p2s_pkg and instantiates p2s_rdiv for the divide by 27.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | req_jac_r*_c*, req_basis_row/col        | taken when start && !busy
//  response  | rsp_stiffness_value                     | rsp_valid strobe, one cycle
//
// One item per cycle; busy stays low. Each result passes through nine register stages:
// products, weighting, two adder levels, rounding, three divide stages and the output
// register.
// Synchronous reset clears the valid bits only; items in flight are dropped.
// The receiver takes every strobe, so nothing holds the pipeline.
`timescale 1ns / 1ps

module p2_triangle_stiffness_entry #(
   parameter int FRAC_BITS = p2s_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_jac_r0_c0,
   input  logic signed [31:0] req_jac_r0_c1,
   input  logic signed [31:0] req_jac_r0_c2,
   input  logic signed [31:0] req_jac_r1_c0,
   input  logic signed [31:0] req_jac_r1_c1,
   input  logic signed [31:0] req_jac_r1_c2,
   input  logic [2:0]         req_basis_row,
   input  logic [2:0]         req_basis_col,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_stiffness_value
);

   localparam int ACC_W = p2s_pkg::ACC_W;
   localparam int QUO_W = ACC_W - 1 - FRAC_BITS;
   localparam int QX = (QUO_W > 64) ? QUO_W : 64;
   localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(p2s_pkg::DIV_K) << FRAC_BITS;
   localparam logic [QX-1:0] SAT_POS = QX'(64'h7FFF_FFFF_FFFF_FFFF);
   localparam logic [QX-1:0] SAT_NEG = QX'(64'h8000_0000_0000_0000);

   logic accept;
   logic signed [31:0] jac_a [p2s_pkg::NUM_QP];
   logic signed [31:0] jac_b [p2s_pkg::NUM_QP];

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   p2s_pkg::tag_type tag5_ff, tag5_in, div_tag;
   logic out_valid_ff, out_neg_ff;

   logic signed [63:0] prod_aa_ff [p2s_pkg::NUM_QP];
   logic signed [63:0] prod_ab_ff [p2s_pkg::NUM_QP];
   logic signed [63:0] prod_bb_ff [p2s_pkg::NUM_QP];
   logic signed [63:0] prod_aa_in [p2s_pkg::NUM_QP];
   logic signed [63:0] prod_ab_in [p2s_pkg::NUM_QP];
   logic signed [63:0] prod_bb_in [p2s_pkg::NUM_QP];
   p2s_pkg::coef_set_type coef_ff, coef_in;

   logic signed [ACC_W-1:0] wt_ff [3 * p2s_pkg::NUM_QP];
   logic signed [ACC_W-1:0] wt_in [3 * p2s_pkg::NUM_QP];
   logic signed [ACC_W-1:0] part_ff [p2s_pkg::NUM_QP];
   logic signed [ACC_W-1:0] part_in [p2s_pkg::NUM_QP];
   logic signed [ACC_W-1:0] sum_ff, sum_in;

   logic [ACC_W-1:0] mag, rnd;
   logic [QUO_W-1:0] num5_ff, num5_in, div_quo;
   logic [QX-1:0] quo_wide;
   logic signed [63:0] res_ff, res_in;

   assign busy = 1'b0;
   assign accept = start && !busy;

   // Gather the Jacobian rows by quadrature column
   always_comb begin
      jac_a[0] = req_jac_r0_c0;
      jac_a[1] = req_jac_r0_c1;
      jac_a[2] = req_jac_r0_c2;
      jac_b[0] = req_jac_r1_c0;
      jac_b[1] = req_jac_r1_c1;
      jac_b[2] = req_jac_r1_c2;
   end

   // Stage 1: entries of J*J^T per column, and the basis pair coefficients
   always_comb begin
      for (int k = 0; k < p2s_pkg::NUM_QP; k++) begin
         prod_aa_in[k] = jac_a[k] * jac_a[k];
         prod_ab_in[k] = jac_a[k] * jac_b[k];
         prod_bb_in[k] = jac_b[k] * jac_b[k];
      end
      coef_in = p2s_pkg::basis_coef(req_basis_row, req_basis_col);
   end

   // Stage 2: weight each product by its coefficient
   always_comb begin
      for (int k = 0; k < p2s_pkg::NUM_QP; k++) begin
         wt_in[3*k]     = coef_ff.c00 * prod_aa_ff[k];
         wt_in[3*k + 1] = coef_ff.c01 * prod_ab_ff[k];
         wt_in[3*k + 2] = coef_ff.c11 * prod_bb_ff[k];
      end
   end

   // Stages 3 and 4: add the weighted terms in two levels
   always_comb begin
      for (int k = 0; k < p2s_pkg::NUM_QP; k++) begin
         part_in[k] = wt_ff[3*k] + wt_ff[3*k + 1] + wt_ff[3*k + 2];
      end
      sum_in = part_ff[0] + part_ff[1] + part_ff[2];
   end

   // Stage 5: take the magnitude, add half the divisor and drop the power of two
   always_comb begin
      tag5_in.valid = v4_ff;
      tag5_in.neg = sum_ff[ACC_W-1];
      mag = sum_ff[ACC_W-1] ? ACC_W'(-sum_ff) : ACC_W'(sum_ff);
      rnd = mag + RND_HALF;
      num5_in = QUO_W'(rnd >> (FRAC_BITS + 1));
   end

   p2s_rdiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rdiv (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (tag5_ff),
      .in_num  (num5_ff),
      .out_tag (div_tag),
      .out_quo (div_quo)
   );

   // Output stage: restore the sign and saturate to 64 bits
   always_comb begin
      quo_wide = QX'(div_quo);
      if (div_tag.neg) begin
         res_in = (quo_wide > SAT_NEG) ? 64'sh8000_0000_0000_0000
                                       : 64'(-quo_wide[63:0]);
      end else begin
         res_in = (quo_wide > SAT_POS) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                       : 64'(quo_wide[63:0]);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         tag5_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         tag5_ff      <= tag5_in;
         out_valid_ff <= div_tag.valid;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      prod_aa_ff <= prod_aa_in;
      prod_ab_ff <= prod_ab_in;
      prod_bb_ff <= prod_bb_in;
      coef_ff    <= coef_in;
      wt_ff      <= wt_in;
      part_ff    <= part_in;
      sum_ff     <= sum_in;
      num5_ff    <= num5_in;
      res_ff     <= res_in;
      out_neg_ff <= div_tag.neg;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_stiffness_value = res_ff;

`ifndef SYNTHESIS
   // Every accepted item gives its result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(p2s_pkg::LATENCY) rsp_valid)
      else $error("item accepted without a result at the expected cycle");

   // No result without an item accepted the latency before
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, p2s_pkg::LATENCY))
      else $error("result strobe with no matching item");

   // A diagonal entry of a positive semidefinite form is never negative
   a_diag_nonneg: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_basis_row == req_basis_col))
         |-> ##(p2s_pkg::LATENCY) !rsp_stiffness_value[63])
      else $error("negative diagonal stiffness entry");

   // A non-negative sum never gives a negative entry
   a_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !out_neg_ff) |-> !rsp_stiffness_value[63])
      else $error("positive sum gave a negative entry");
`endif

endmodule

// ===== design/p2s_rdiv.sv =====
// Pipelined divide by 27 of the rounded magnitude, by reciprocal multiply and correction.
// Depends on p2s_pkg for the divisor, accumulator width and tag type.
`timescale 1ns / 1ps

module p2s_rdiv #(
   parameter int FRAC_BITS = p2s_pkg::FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  p2s_pkg::tag_type                           in_tag,
   input  logic [p2s_pkg::ACC_W-2-FRAC_BITS:0]        in_num,
   output p2s_pkg::tag_type                           out_tag,
   output logic [p2s_pkg::ACC_W-2-FRAC_BITS:0]        out_quo
);

   localparam int QW = p2s_pkg::ACC_W - 1 - FRAC_BITS;
   localparam int XH = (QW + 1) / 2;
   localparam int XU = QW - XH;
   localparam int PW = 2 * QW;
   localparam logic [QW:0] POW_W = {1'b1, {QW{1'b0}}};
   localparam logic [QW:0] RECIP_FULL = POW_W / (QW + 1)'(p2s_pkg::DIV_K);
   localparam logic [QW-1:0] RECIP = RECIP_FULL[QW-1:0];
   localparam logic [XH-1:0] M_LO = RECIP[XH-1:0];
   localparam logic [XU-1:0] M_HI = RECIP[QW-1:XH];

   p2s_pkg::tag_type tag_d1_ff, tag_d2_ff, tag_d3_ff;
   logic [QW-1:0] num_d1_ff, num_d2_ff;
   logic [2*XH-1:0] pp_ll_ff, pp_ll_in;
   logic [XH+XU-1:0] pp_lh_ff, pp_lh_in, pp_hl_ff, pp_hl_in;
   logic [2*XU-1:0] pp_hh_ff, pp_hh_in;
   logic [PW-1:0] prod_sum;
   logic [QW-1:0] q_est_ff, q_est_in;
   logic [QW-1:0] prod27, rem_est;
   logic [QW-1:0] quo_ff, quo_in;

   // Partial products of numerator and reciprocal
   always_comb begin
      pp_ll_in = in_num[XH-1:0] * M_LO;
      pp_lh_in = in_num[XH-1:0] * M_HI;
      pp_hl_in = in_num[QW-1:XH] * M_LO;
      pp_hh_in = in_num[QW-1:XH] * M_HI;
   end

   // Combine partial products; the estimate is the true quotient or one below it
   always_comb begin
      prod_sum = (PW'(pp_hh_ff) << (2 * XH))
               + ((PW'(pp_lh_ff) + PW'(pp_hl_ff)) << XH)
               + PW'(pp_ll_ff);
      q_est_in = prod_sum[PW-1:QW];
   end

   // Correct the estimate from the remainder
   always_comb begin
      prod27 = (q_est_ff << 4) + (q_est_ff << 3) + (q_est_ff << 1) + q_est_ff;
      rem_est = num_d2_ff - prod27;
      quo_in = q_est_ff + QW'(rem_est >= QW'(p2s_pkg::DIV_K));
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d1_ff <= '0;
         tag_d2_ff <= '0;
         tag_d3_ff <= '0;
      end else begin
         tag_d1_ff <= in_tag;
         tag_d2_ff <= tag_d1_ff;
         tag_d3_ff <= tag_d2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      num_d1_ff <= in_num;
      pp_ll_ff  <= pp_ll_in;
      pp_lh_ff  <= pp_lh_in;
      pp_hl_ff  <= pp_hl_in;
      pp_hh_ff  <= pp_hh_in;
      num_d2_ff <= num_d1_ff;
      q_est_ff  <= q_est_in;
      quo_ff    <= quo_in;
   end

   assign out_tag = tag_d3_ff;
   assign out_quo = quo_ff;

`ifndef SYNTHESIS
   // The reciprocal estimate must never be more than one short
   a_est_within_one: assert property (@(posedge clock) disable iff (reset)
      tag_d2_ff.valid |-> (rem_est < QW'(2 * p2s_pkg::DIV_K)))
      else $error("divide estimate off by more than one");

   // An item leaves only after passing tag_d1_ff, tag_d2_ff and tag_d3_ff
   a_tag_latency: assert property (@(posedge clock) disable iff (reset)
      tag_d3_ff.valid |-> $past(in_tag.valid, 3))
      else $error("divide stage produced an item that never entered");
`endif

endmodule

// ===== sim/p2_triangle_stiffness_entry_tb.sv =====
// Self-checking testbench for p2_triangle_stiffness_entry: directed corner items and
// random Jacobians, each checked against an exact 128-bit stiffness predictor.
// Depends on p2s_pkg and the p2_triangle_stiffness_entry design.
`timescale 1ns / 1ps

module p2_triangle_stiffness_entry_tb;

   localparam int FRAC = p2s_pkg::FRAC_BITS_DEF;
   localparam int STALL_LIMIT = 500;
   localparam int RANDOM_ITEMS = 1350;
   localparam logic signed [31:0] J_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] J_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q = 32'sd65536;

   // Three times the basis gradients: [basis][point][x, y], flattened
   localparam int GRAD_X3 [0:35] = '{
      -5, -5,  1,  1,  1,  1,
      -1,  0,  5,  0, -1,  0,
       0, -1,  0, -1,  0,  5,
       6, -2, -6, -8,  0, -2,
       2,  2,  2,  8,  8,  2,
      -2,  6, -2,  0, -8, -6
   };

   typedef enum int {
      DRAW_FULL,
      DRAW_Q16,
      DRAW_TINY,
      DRAW_EDGE
   } draw_kind_type;

   typedef struct packed {
      logic signed [31:0] r0c0;
      logic signed [31:0] r0c1;
      logic signed [31:0] r0c2;
      logic signed [31:0] r1c0;
      logic signed [31:0] r1c1;
      logic signed [31:0] r1c2;
      logic [2:0]         row;
      logic [2:0]         col;
   } stiff_req_type;

   // Predicts each entry and checks the results in order
   class stiffness_board;
      logic signed [63:0] entries_due[$];
      int unsigned n_checked;
      int unsigned n_errors;

      function new();
         n_checked = 0;
         n_errors = 0;
      endfunction

      // Exact sum of weighted Jacobian products, then divide by 54 * 2^FRAC
      function logic signed [63:0] predict_entry(stiff_req_type it);
         logic signed [127:0] j0 [3];
         logic signed [127:0] j1 [3];
         logic signed [127:0] sum;
         logic signed [127:0] mag;
         logic signed [127:0] quo;
         logic neg;
         int bi, bj, c00, c01, c11, ix, iy, jx, jy;
         bi = (it.row > p2s_pkg::BASIS_LAST) ? int'(p2s_pkg::BASIS_LAST) : int'(it.row);
         bj = (it.col > p2s_pkg::BASIS_LAST) ? int'(p2s_pkg::BASIS_LAST) : int'(it.col);
         c00 = 0;
         c01 = 0;
         c11 = 0;
         for (int k = 0; k < 3; k++) begin
            ix = GRAD_X3[bi * 6 + k * 2];
            iy = GRAD_X3[bi * 6 + k * 2 + 1];
            jx = GRAD_X3[bj * 6 + k * 2];
            jy = GRAD_X3[bj * 6 + k * 2 + 1];
            c00 += ix * jx;
            c01 += ix * jy + iy * jx;
            c11 += iy * jy;
         end
         j0[0] = it.r0c0;
         j0[1] = it.r0c1;
         j0[2] = it.r0c2;
         j1[0] = it.r1c0;
         j1[1] = it.r1c1;
         j1[2] = it.r1c2;
         sum = '0;
         for (int k = 0; k < 3; k++)
            sum = sum + c00 * j0[k] * j0[k] + c01 * j0[k] * j1[k] + c11 * j1[k] * j1[k];
         // round half away from zero on the magnitude
         neg = (sum < 0);
         mag = neg ? -sum : sum;
         quo = ((mag + (128'sd27 <<< FRAC)) >>> (FRAC + 1)) / 128'sd27;
         if (neg) begin
            if (quo > (128'sd1 <<< 63))
               return 64'sh8000_0000_0000_0000;
            return 64'(-quo);
         end
         if (quo > ((128'sd1 <<< 63) - 1))
            return 64'sh7FFF_FFFF_FFFF_FFFF;
         return quo[63:0];
      endfunction

      function void note_item(stiff_req_type it);
         entries_due.push_back(predict_entry(it));
      endfunction

      function void check_entry(logic signed [63:0] got);
         logic signed [63:0] want;
         n_checked++;
         if (entries_due.size() == 0) begin
            $error("stiffness_value: no item waiting, actual %0d", got);
            n_errors++;
            return;
         end
         want = entries_due.pop_front();
         if (got !== want) begin
            $error("stiffness_value: expected %0d, actual %0d", want, got);
            n_errors++;
         end
      endfunction

      function int pending();
         return entries_due.size();
      endfunction

      function void drain_report();
         if (entries_due.size() != 0) begin
            $error("stiffness_value: %0d results never arrived", entries_due.size());
            n_errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_jac_r0_c0;
   logic signed [31:0] req_jac_r0_c1;
   logic signed [31:0] req_jac_r0_c2;
   logic signed [31:0] req_jac_r1_c0;
   logic signed [31:0] req_jac_r1_c1;
   logic signed [31:0] req_jac_r1_c2;
   logic [2:0]         req_basis_row;
   logic [2:0]         req_basis_col;
   logic               rsp_valid;
   logic signed [63:0] rsp_stiffness_value;

   stiffness_board board;
   int idle_cycles = 0;
   int n_directed = 0;
   int n_random = 0;

   p2_triangle_stiffness_entry uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_jac_r0_c0       (req_jac_r0_c0),
      .req_jac_r0_c1       (req_jac_r0_c1),
      .req_jac_r0_c2       (req_jac_r0_c2),
      .req_jac_r1_c0       (req_jac_r1_c0),
      .req_jac_r1_c1       (req_jac_r1_c1),
      .req_jac_r1_c2       (req_jac_r1_c2),
      .req_basis_row       (req_basis_row),
      .req_basis_col       (req_basis_col),
      .rsp_valid           (rsp_valid),
      .rsp_stiffness_value (rsp_stiffness_value)
   );

   always #10 clock = ~clock;

   // Check each result strobe, then note any item taken at this edge
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1)
            board.check_entry(rsp_stiffness_value);
         if (start === 1'b1 && busy === 1'b0)
            board.note_item(make_req(req_jac_r0_c0, req_jac_r0_c1, req_jac_r0_c2,
                                     req_jac_r1_c0, req_jac_r1_c1, req_jac_r1_c2,
                                     req_basis_row, req_basis_col));
      end
   end

   // Stop the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset === 1'b1 || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic stiff_req_type make_req(logic signed [31:0] a0, logic signed [31:0] a1,
                                              logic signed [31:0] a2, logic signed [31:0] b0,
                                              logic signed [31:0] b1, logic signed [31:0] b2,
                                              logic [2:0] row, logic [2:0] col);
      stiff_req_type it;
      it = '{a0, a1, a2, b0, b1, b2, row, col};
      return it;
   endfunction

   function automatic logic signed [31:0] draw_entry(draw_kind_type kind);
      case (kind)
         DRAW_FULL: return $urandom;
         DRAW_Q16:  return int'($urandom_range(0, 1048576)) - 524288;
         DRAW_TINY: return int'($urandom_range(0, 600)) - 300;
         default: begin
            case ($urandom_range(0, 4))
               0:       return J_MAX;
               1:       return J_MIN;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   // Random Jacobian of one scale; a third of the items are planar
   function automatic stiff_req_type draw_req();
      stiff_req_type it;
      draw_kind_type kind;
      int pick;
      pick = $urandom_range(0, 9);
      kind = (pick < 3) ? DRAW_FULL : (pick < 7) ? DRAW_Q16 : (pick < 9) ? DRAW_TINY : DRAW_EDGE;
      it.r0c0 = draw_entry(kind);
      it.r0c1 = draw_entry(kind);
      it.r0c2 = draw_entry(kind);
      it.r1c0 = draw_entry(kind);
      it.r1c1 = draw_entry(kind);
      it.r1c2 = draw_entry(kind);
      if ($urandom_range(0, 2) == 0) begin
         it.r0c2 = '0;
         it.r1c2 = '0;
      end
      it.row = 3'($urandom_range(0, 7));
      it.col = 3'($urandom_range(0, 7));
      return it;
   endfunction

   // Hold start low for the gap, then present the item until it is taken
   task automatic send_item(stiff_req_type it, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_jac_r0_c0 <= it.r0c0;
      req_jac_r0_c1 <= it.r0c1;
      req_jac_r0_c2 <= it.r0c2;
      req_jac_r1_c0 <= it.r1c0;
      req_jac_r1_c1 <= it.r1c1;
      req_jac_r1_c2 <= it.r1c2;
      req_basis_row <= it.row;
      req_basis_col <= it.col;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start and wait for every outstanding result
   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic send_directed(stiff_req_type it);
      send_item(it, $urandom_range(0, 6));
      n_directed++;
   endtask

   initial begin
      bit burst;
      int gap;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_jac_r0_c0 = '0;
      req_jac_r0_c1 = '0;
      req_jac_r0_c2 = '0;
      req_jac_r1_c0 = '0;
      req_jac_r1_c1 = '0;
      req_jac_r1_c2 = '0;
      req_basis_row = '0;
      req_basis_col = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, full-scale extremes, mixed signs
      send_directed(make_req(0, 0, 0, 0, 0, 0, 3'd0, 3'd0));
      send_directed(make_req(J_MAX, J_MAX, J_MAX, J_MAX, J_MAX, J_MAX, 3'd0, 3'd0));
      send_directed(make_req(J_MIN, J_MIN, J_MIN, J_MIN, J_MIN, J_MIN, 3'd5, 3'd5));
      send_directed(make_req(J_MAX, J_MAX, J_MAX, J_MIN, J_MIN, J_MIN, 3'd3, 3'd4));
      send_directed(make_req(J_MIN, J_MAX, J_MIN, J_MAX, J_MIN, J_MAX, 3'd4, 3'd5));
      send_directed(make_req(-1, -1, -1, -1, -1, -1, 3'd2, 3'd3));
      // Identity element over every index code, including the aliased six and seven
      for (int i = 0; i < 8; i++)
         send_directed(make_req(ONE_Q, 0, 0, 0, ONE_Q, 0, 3'(i), 3'(7 - i)));
      send_directed(make_req(ONE_Q, 0, ONE_Q, 0, ONE_Q, -ONE_Q, 3'd6, 3'd7));
      // Exact halves: positive and negative ties, and just off a tie
      send_directed(make_req(256, 0, 0, 0, 0, 0, 3'd1, 3'd1));
      send_directed(make_req(128, 64, 64, 0, 0, 0, 3'd4, 3'd5));
      send_directed(make_req(255, 0, 0, 0, 0, 0, 3'd1, 3'd1));
      send_directed(make_req(-128, 64, -64, 0, 0, 0, 3'd5, 3'd4));
      drain_pipeline();

      // Random: bursts without gaps alternate with random sender gaps
      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0)
            burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2)
            drain_pipeline();
         gap = burst ? 0 : $urandom_range(0, 6);
         send_item(draw_req(), gap);
         n_random++;
      end

      drain_pipeline();
      repeat (p2s_pkg::LATENCY + 4) @(posedge clock);
      board.drain_report();
      $display("Covered %0d items (%0d directed, %0d random), %0d results checked,",
               n_directed + n_random, n_directed, n_random, board.n_checked);
      $display("with basis codes 0 to 7, full-range and Q16.16 Jacobians, ties and gaps.");
      if (board.n_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
